>>> sv/lp2sc_pkg.sv
// Shared types and codes for the length-prefix to start-code converter.
// No dependencies; imported by h264_length_prefix_to_start_code.
`default_nettype none

package lp2sc_pkg;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // Input request kinds (carried on in_tuser)
  localparam logic CMD_STORE  = 1'b0;
  localparam logic CMD_STREAM = 1'b1;

  // NAL unit types of interest
  localparam logic [4:0] NAL_SLICE = 5'd1;
  localparam logic [4:0] NAL_IDR   = 5'd5;
  localparam logic [4:0] NAL_SPS   = 5'd7;
  localparam logic [4:0] NAL_PPS   = 5'd8;

  localparam logic [4:0] NAL_TYPE_MASK = 5'h1f;
  localparam logic [7:0] SC_LAST_BYTE  = 8'h01;

  // Prefix byte counter value on the final length byte
  localparam logic [1:0] PREFIX_LAST = 2'd3;

  // Start code lengths
  localparam logic [2:0] SC_LONG  = 3'd4;
  localparam logic [2:0] SC_SHORT = 3'd3;

endpackage

`default_nettype wire

>>> sv/h264_length_prefix_to_start_code.sv
// Converts H.264 units with 4-byte big-endian length prefixes into Annex B bytes.
// Depends on lp2sc_pkg (state type, NAL type codes, request kinds).
`default_nettype none

// Input requests are either parameter-set store writes (in_tuser = 0) or stream bytes
// (in_tuser = 1, in_tlast on the last byte of a packet). Each length prefix is replaced
// by a start code: 00 00 00 01 for a packet's first unit and SPS/PPS or replayed units,
// 00 00 01 otherwise. The first byte of a unit is held until its second byte arrives.
// Before the first IDR slice of a picture, or a PPS with no SPS earlier in the packet,
// the first param_set_length bytes of the store are replayed (saturated at
// PARAM_SET_DEPTH). A packet that ends inside a prefix or a unit, or that carried a
// length of 2^31 or more, closes with a bare status result with format_error set.
// Timing: a stream byte that makes at most one result is taken every cycle unless the
// output stalls; a request making k results holds in_tready low until its last result
// goes out, as the single output register sends one result per cycle. Prepended bytes
// come from the store memory at one byte per cycle (synchronous read, address taken
// from the next value of the replay pointer). Store writes produce no result. No
// clearing pass: store entries are valid only once written. Configuration is taken at
// any time, but should change only while the block is idle.
module h264_length_prefix_to_start_code
  import lp2sc_pkg::*;
#(
  parameter int PARAM_SET_DEPTH = 48
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration: param_set_length
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,  // [7:0] data_byte, [13:8] store_index, [15:14] zero
  input  wire logic        in_tuser,  // [0] cmd
  input  wire logic        in_tlast,  // packet_last
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata, // [7:0] out_byte
  output logic [2:0]       out_tuser, // [0] byte_valid, [1] run_last, [2] format_error
  output logic             out_tlast  // packet_done
);

  localparam int IW = (PARAM_SET_DEPTH > 1) ? $clog2(PARAM_SET_DEPTH) : 1;
  localparam int CW = $clog2(PARAM_SET_DEPTH + 1);
  localparam int RW = CW + 2;

  // ---------------------------------------------------------------- storage
  logic [7:0] ps_mem [PARAM_SET_DEPTH];
  logic [7:0] mem_q_r;

  // ---------------------------------------------------------------- state
  state_t      state_r, state_nxt;
  logic [5:0]  psl_r;

  logic [1:0]  cnt_r, cnt_nxt;
  logic        payload_r, payload_nxt;
  logic [31:0] left_r, left_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        hh_r, hh_nxt;
  logic        idr_r, idr_nxt;
  logic        sps_r, sps_nxt;
  logic        pps_r, pps_nxt;
  logic        first_r, first_nxt;
  logic        await_r, await_nxt;
  logic        err_r, err_nxt;

  // emission plan of the current request
  logic [CW-1:0] prep_left_r, prep_left_nxt;
  logic [CW-1:0] prep_idx_r, prep_idx_nxt;
  logic [2:0]    sc_left_r, sc_left_nxt;
  logic [1:0]    nb_r, nb_nxt;
  logic [7:0]    b0_r, b0_nxt;
  logic [7:0]    b1_r, b1_nxt;
  logic          status_r, status_nxt;
  logic          fe_r, fe_nxt;
  logic          plast_r, plast_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [2:0] out_user_r, out_user_nxt;
  logic       out_last_r, out_last_nxt;

  // ---------------------------------------------------------------- input decode
  logic       in_acc;
  logic [7:0] in_byte;
  logic [5:0] in_idx;
  logic [CW-1:0] len_sat;

  assign in_byte = in_tdata[7:0];
  assign in_idx  = in_tdata[13:8];
  assign in_acc  = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign len_sat = (int'(psl_r) > PARAM_SET_DEPTH) ? CW'(PARAM_SET_DEPTH) : CW'(psl_r);

  // ---------------------------------------------------------------- emission side
  logic          slot_free, emit, final_res;
  logic [RW-1:0] rem;

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = (state_r == ST_EMIT) && slot_free;
  assign rem       = RW'(prep_left_r) + RW'(sc_left_r) + RW'(nb_r) + RW'(status_r);
  assign final_res = (rem == RW'(1));

  assign in_tready = (state_r == ST_IDLE) || (emit && final_res);

  // ---------------------------------------------------------------- request decode
  // New per-packet state and the emission plan of an accepted stream byte.
  logic [7:0]    su_b0;
  logic          su_do, su_top, zl;
  logic [4:0]    su_type;
  logic          su_prepend, su_ps, su_done;
  logic          su_idr, su_sps, su_pps;
  logic [31:0]   left_dec;
  logic          err_end, no_res;
  logic [CW-1:0] pl_prep;
  logic [2:0]    pl_sc;
  logic [1:0]    pl_nb;
  logic [7:0]    pl_b0, pl_b1;
  logic          pl_status, pl_fe;

  always_comb begin
    cnt_nxt     = cnt_r;
    payload_nxt = payload_r;
    left_nxt    = left_r;
    held_nxt    = held_r;
    hh_nxt      = hh_r;
    idr_nxt     = idr_r;
    sps_nxt     = sps_r;
    pps_nxt     = pps_r;
    first_nxt   = first_r;
    await_nxt   = await_r;
    err_nxt     = err_r;
    pl_prep     = '0;
    pl_sc       = '0;
    pl_nb       = '0;
    pl_b0       = in_byte;
    pl_b1       = in_byte;
    pl_status   = 1'b0;
    pl_fe       = 1'b0;
    su_do       = 1'b0;
    su_b0       = in_byte;
    su_top      = 1'b0;
    zl          = 1'b0;
    left_dec    = left_r - 32'd1;

    priority if (err_r) begin
      // dropping until packet end
    end else if (!payload_r) begin
      left_nxt = {left_r[23:0], in_byte};
      cnt_nxt  = cnt_r + 2'd1;
      if (cnt_r == PREFIX_LAST) begin
        priority if (left_nxt[31]) begin
          err_nxt = 1'b1;
        end else if (left_nxt == 32'd0) begin
          zl = 1'b1;
        end else begin
          payload_nxt = 1'b1;
          await_nxt   = 1'b1;
          hh_nxt      = 1'b0;
        end
      end
    end else if (await_r) begin
      await_nxt = 1'b0;
      left_nxt  = left_dec;
      if (left_dec == 32'd0) begin
        su_do       = 1'b1;
        pl_nb       = 2'd1;
        payload_nxt = 1'b0;
      end else begin
        held_nxt = in_byte;
        hh_nxt   = 1'b1;
      end
    end else if (hh_r) begin
      hh_nxt   = 1'b0;
      su_do    = 1'b1;
      su_b0    = held_r;
      su_top   = in_byte[7];
      pl_nb    = 2'd2;
      pl_b0    = held_r;
      pl_b1    = in_byte;
      left_nxt = left_dec;
      if (left_dec == 32'd0) payload_nxt = 1'b0;
    end else begin
      pl_nb    = 2'd1;
      left_nxt = left_dec;
      if (left_dec == 32'd0) payload_nxt = 1'b0;
    end

    // start of a unit: prepend and start-code decision from the header byte
    su_type    = su_b0[4:0] & NAL_TYPE_MASK;
    su_idr     = idr_r;
    su_sps     = sps_r;
    su_pps     = pps_r;
    su_prepend = 1'b0;
    su_ps      = 1'b0;
    su_done    = 1'b0;
    if (su_type == NAL_SPS) begin
      su_sps = 1'b1;
      su_idr = 1'b1;
      su_ps  = 1'b1;
    end else if (su_type == NAL_PPS) begin
      su_pps = 1'b1;
      su_idr = 1'b1;
      su_ps  = 1'b1;
      if (!sps_r) begin
        su_prepend = 1'b1;
        su_sps     = 1'b1;
        su_done    = 1'b1;
      end
    end
    if (!su_done) begin
      if (!su_idr && su_type == NAL_IDR && su_top) su_idr = 1'b1;
      priority if (su_idr && su_type == NAL_IDR && !su_sps && !su_pps) begin
        su_prepend = 1'b1;
        su_ps      = 1'b1;
        su_idr     = 1'b0;
      end else if (su_idr && su_type == NAL_IDR && su_sps && !su_pps) begin
        su_prepend = 1'b1;
        su_ps      = 1'b1;
      end else if (!su_idr && su_type == NAL_SLICE) begin
        su_idr = 1'b1;
        su_sps = 1'b0;
        su_pps = 1'b0;
      end else begin
      end
    end

    if (su_do) begin
      idr_nxt   = su_idr;
      sps_nxt   = su_sps;
      pps_nxt   = su_pps;
      pl_prep   = su_prepend ? len_sat : '0;
      pl_sc     = (first_r || su_ps) ? SC_LONG : SC_SHORT;
      first_nxt = 1'b0;
    end
    if (zl) begin
      pl_sc     = first_r ? SC_LONG : SC_SHORT;
      first_nxt = 1'b0;
    end

    // packet end: status result and per-packet reset
    err_end = err_nxt || (cnt_nxt != 2'd0) || payload_nxt;
    no_res  = (pl_prep == '0) && (pl_sc == 3'd0) && (pl_nb == 2'd0);
    if (in_tlast) begin
      pl_status   = err_end || no_res;
      pl_fe       = err_end;
      cnt_nxt     = '0;
      payload_nxt = 1'b0;
      left_nxt    = '0;
      held_nxt    = '0;
      hh_nxt      = 1'b0;
      idr_nxt     = 1'b0;
      sps_nxt     = 1'b0;
      pps_nxt     = 1'b0;
      first_nxt   = 1'b1;
      await_nxt   = 1'b0;
      err_nxt     = 1'b0;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_nxt     = state_r;
    prep_left_nxt = prep_left_r;
    prep_idx_nxt  = prep_idx_r;
    sc_left_nxt   = sc_left_r;
    nb_nxt        = nb_r;
    b0_nxt        = b0_r;
    b1_nxt        = b1_r;
    status_nxt    = status_r;
    fe_nxt        = fe_r;
    plast_nxt     = plast_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;

    if (out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        prep_idx_nxt = '0;
      end
      ST_EMIT: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = {1'b0, final_res, 1'b1};
          out_last_nxt  = final_res && plast_r;
          priority if (prep_left_r != '0) begin
            out_byte_nxt  = mem_q_r;
            prep_left_nxt = prep_left_r - CW'(1);
            prep_idx_nxt  = prep_idx_r + CW'(1);
          end else if (sc_left_r != 3'd0) begin
            out_byte_nxt = (sc_left_r == 3'd1) ? SC_LAST_BYTE : 8'h00;
            sc_left_nxt  = sc_left_r - 3'd1;
          end else if (nb_r != 2'd0) begin
            out_byte_nxt = b0_r;
            b0_nxt       = b1_r;
            nb_nxt       = nb_r - 2'd1;
          end else begin
            // bare status result
            out_byte_nxt = 8'h00;
            out_user_nxt = {fe_r, final_res, 1'b0};
            status_nxt   = 1'b0;
          end
          if (final_res) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // a new stream byte loads the next plan
    if (in_acc && in_tuser == CMD_STREAM) begin
      prep_left_nxt = pl_prep;
      prep_idx_nxt  = '0;
      sc_left_nxt   = pl_sc;
      nb_nxt        = pl_nb;
      b0_nxt        = pl_b0;
      b1_nxt        = pl_b1;
      status_nxt    = pl_status;
      fe_nxt        = pl_fe;
      plast_nxt     = in_tlast;
      state_nxt     = (no_res && !pl_status) ? ST_IDLE : ST_EMIT;
    end
  end

  // ---------------------------------------------------------------- memory
  logic [IW-1:0] rd_addr;
  assign rd_addr = (int'(prep_idx_nxt) < PARAM_SET_DEPTH) ? prep_idx_nxt[IW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == CMD_STORE && int'(in_idx) < PARAM_SET_DEPTH) begin
      ps_mem[in_idx[IW-1:0]] <= in_byte;
    end
    mem_q_r <= ps_mem[rd_addr];
  end

  // ---------------------------------------------------------------- registers
  logic st_acc;
  assign st_acc = in_acc && in_tuser == CMD_STREAM;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      psl_r       <= '0;
      cnt_r       <= '0;
      payload_r   <= 1'b0;
      left_r      <= '0;
      held_r      <= '0;
      hh_r        <= 1'b0;
      idr_r       <= 1'b0;
      sps_r       <= 1'b0;
      pps_r       <= 1'b0;
      first_r     <= 1'b1;
      await_r     <= 1'b0;
      err_r       <= 1'b0;
      prep_left_r <= '0;
      prep_idx_r  <= '0;
      sc_left_r   <= '0;
      nb_r        <= '0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_valid && cfg_ready) psl_r <= cfg_data;
      if (st_acc) begin
        cnt_r     <= cnt_nxt;
        payload_r <= payload_nxt;
        left_r    <= left_nxt;
        held_r    <= held_nxt;
        hh_r      <= hh_nxt;
        idr_r     <= idr_nxt;
        sps_r     <= sps_nxt;
        pps_r     <= pps_nxt;
        first_r   <= first_nxt;
        await_r   <= await_nxt;
        err_r     <= err_nxt;
      end
      prep_left_r <= prep_left_nxt;
      prep_idx_r  <= prep_idx_nxt;
      sc_left_r   <= sc_left_nxt;
      nb_r        <= nb_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    fe_r       <= fe_nxt;
    plast_r    <= plast_nxt;
    out_byte_r <= out_byte_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
// Self-checking testbench for h264_length_prefix_to_start_code.
// Depends on lp2sc_pkg and the converter RTL; a built-in predictor tracks the
// conversion and every output request is checked against it in order.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lp2sc_pkg::*;

  localparam int PS_DEPTH        = 48;
  localparam int TX_GAP_DEFAULT  = 14;
  localparam int RX_GAP_DEFAULT  = 14;
  localparam int RX_HOLD_CYCLES  = 300;  // long output stall so the block backs up
  localparam int DRAIN_SETTLE    = 8;    // no-result requests may still be in flight
  localparam int END_SETTLE      = 16;
  localparam int WATCHDOG_LIMIT  = 3000; // cycles without any handshake

  // One output request as seen on the result stream
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       packet_done;
    logic       format_error;
  } annexb_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [5:0]  cfg_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] data_byte, [13:8] store_index, [15:14] zero
  logic        in_tuser;   // [0] cmd
  logic        in_tlast;   // packet_last
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [7:0] out_byte
  logic [2:0]  out_tuser;  // [0] byte_valid, [1] run_last, [2] format_error
  logic        out_tlast;  // packet_done

  always #5 clk = ~clk;

  h264_length_prefix_to_start_code #(
    .PARAM_SET_DEPTH(PS_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a mirror of the converter's per-packet bookkeeping
  // ---------------------------------------------------------------------------
  logic [7:0]   ps_store [PS_DEPTH];  // stored SPS+PPS bytes
  logic [5:0]   ps_length = '0;       // config register
  logic [1:0]   pfx_count = '0;       // length prefix bytes seen, mod 4
  logic [31:0]  bytes_left = '0;      // prefix shift register / payload countdown
  logic [7:0]   held_hdr = '0;        // unit header byte waiting for byte two
  bit           in_payload, hdr_held, idr_pend, sps_seen, pps_seen;
  bit           await_first, err_latched;
  bit           first_unit = 1'b1;

  annexb_beat_t item_beats[$];        // results of the request being predicted
  annexb_beat_t expected_beats[$];    // results still owed by the block
  logic [7:0]   pkt_bytes[$];         // packet under construction

  int mismatches = 0;
  int tx_gap_max = TX_GAP_DEFAULT;
  int rx_gap_max = RX_GAP_DEFAULT;
  bit rx_hold_req = 1'b0;

  function automatic void push_beat(logic [7:0] b, logic v);
    annexb_beat_t r;
    r = '{out_byte: b, byte_valid: v, run_last: 1'b0, packet_done: 1'b0,
          format_error: 1'b0};
    item_beats.push_back(r);
  endfunction

  // Optional parameter-set replay, then a 4- or 3-byte start code
  function automatic void emit_start_code(bit prepend, bit ps);
    int n;
    int i;
    n = (ps_length > PS_DEPTH) ? PS_DEPTH : int'(ps_length);
    if (prepend) begin
      for (i = 0; i < n; i++) push_beat(ps_store[i], 1'b1);
    end
    if (first_unit || ps) push_beat(8'h00, 1'b1);
    push_beat(8'h00, 1'b1);
    push_beat(8'h00, 1'b1);
    push_beat(SC_LAST_BYTE, 1'b1);
    first_unit = 1'b0;
  endfunction

  // Decide start code and replay from the unit header and the top bit of byte two
  function automatic void open_unit(logic [7:0] b0, logic b1top);
    logic [4:0] ntype;
    bit prepend;
    bit ps;
    bit done;
    ntype   = b0[4:0] & NAL_TYPE_MASK;
    prepend = 1'b0;
    ps      = 1'b0;
    done    = 1'b0;
    if (ntype == NAL_SPS) begin
      sps_seen = 1'b1;
      idr_pend = 1'b1;
      ps       = 1'b1;
    end else if (ntype == NAL_PPS) begin
      pps_seen = 1'b1;
      idr_pend = 1'b1;
      ps       = 1'b1;
      // PPS without an SPS earlier in the packet gets the stored sets
      if (!sps_seen) begin
        prepend  = 1'b1;
        sps_seen = 1'b1;
        done     = 1'b1;
      end
    end
    if (!done) begin
      // top bit of byte two set: slice starts at macroblock zero, a new picture
      if (!idr_pend && ntype == NAL_IDR && b1top) idr_pend = 1'b1;
      if (idr_pend && ntype == NAL_IDR && !sps_seen && !pps_seen) begin
        prepend  = 1'b1;
        ps       = 1'b1;
        idr_pend = 1'b0;
      end else if (idr_pend && ntype == NAL_IDR && sps_seen && !pps_seen) begin
        prepend = 1'b1;
        ps      = 1'b1;
      end else if (!idr_pend && ntype == NAL_SLICE) begin
        idr_pend = 1'b1;
        sps_seen = 1'b0;
        pps_seen = 1'b0;
      end
    end
    emit_start_code(prepend, ps);
  endfunction

  function automatic void clear_packet();
    pfx_count   = '0;
    in_payload  = 1'b0;
    bytes_left  = '0;
    held_hdr    = '0;
    hdr_held    = 1'b0;
    idr_pend    = 1'b0;
    sps_seen    = 1'b0;
    pps_seen    = 1'b0;
    first_unit  = 1'b1;
    await_first = 1'b0;
    err_latched = 1'b0;
  endfunction

  // Expected results for one accepted input request
  function automatic void predict_conversion(logic cmd, logic [7:0] b, logic [5:0] idx,
                                             logic last);
    bit err;
    int tail;
    item_beats.delete();
    if (cmd == CMD_STORE) begin
      if (idx < PS_DEPTH) ps_store[idx] = b;
      return;
    end
    if (err_latched) begin
      // oversize length seen: bytes dropped until packet end
    end else if (!in_payload) begin
      bytes_left = {bytes_left[23:0], b};
      pfx_count  = pfx_count + 2'd1;
      if (pfx_count == 2'd0) begin
        if (bytes_left[31]) err_latched = 1'b1;
        else if (bytes_left == 32'd0) emit_start_code(1'b0, 1'b0);
        else begin
          in_payload  = 1'b1;
          await_first = 1'b1;
          hdr_held    = 1'b0;
        end
      end
    end else if (await_first) begin
      await_first = 1'b0;
      bytes_left  = bytes_left - 32'd1;
      if (bytes_left == 32'd0) begin
        // one-byte unit: byte two's top bit taken as zero
        open_unit(b, 1'b0);
        push_beat(b, 1'b1);
        in_payload = 1'b0;
      end else begin
        held_hdr = b;
        hdr_held = 1'b1;
      end
    end else if (hdr_held) begin
      hdr_held = 1'b0;
      open_unit(held_hdr, b[7]);
      push_beat(held_hdr, 1'b1);
      push_beat(b, 1'b1);
      bytes_left = bytes_left - 32'd1;
      if (bytes_left == 32'd0) in_payload = 1'b0;
    end else begin
      push_beat(b, 1'b1);
      bytes_left = bytes_left - 32'd1;
      if (bytes_left == 32'd0) in_payload = 1'b0;
    end

    if (last) begin
      err = err_latched || pfx_count != 2'd0 || in_payload;
      // truncation / oversize, or nothing else to carry packet_done: bare status
      if (err || item_beats.size() == 0) begin
        push_beat(8'h00, 1'b0);
        tail = item_beats.size() - 1;
        item_beats[tail].format_error = err;
      end
      tail = item_beats.size() - 1;
      item_beats[tail].packet_done = 1'b1;
      clear_packet();
    end
    if (item_beats.size() > 0) begin
      tail = item_beats.size() - 1;
      item_beats[tail].run_last = 1'b1;
    end
    foreach (item_beats[k]) expected_beats.push_back(item_beats[k]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one request per call; valid stays up if the next call has no gap
  // ---------------------------------------------------------------------------
  task automatic send_request(input logic cmd, input logic [7:0] data,
                              input logic [5:0] idx, input logic last);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, idx, data};
    in_tuser  <= cmd;
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_conversion(cmd, data, idx, last);
  endtask

  task automatic park_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    park_input();
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Register write only with the block idle
  task automatic write_param_length(input logic [5:0] value);
    wait_drained();
    repeat (DRAIN_SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    ps_length = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_packet();
    int k;
    for (k = 0; k < pkt_bytes.size(); k++)
      send_request(CMD_STREAM, pkt_bytes[k], 6'($urandom_range(0, 63)),
                   k == pkt_bytes.size() - 1);
  endtask

  // Well-formed packet of 1..4 units, optionally cut short or with oversize length
  task automatic build_random_packet(input bit broken);
    int units;
    int u;
    int len;
    int j;
    int cut;
    logic [4:0] ntype;
    pkt_bytes.delete();
    if (broken && $urandom_range(0, 1) == 1) begin
      pkt_bytes.push_back(8'($urandom_range(128, 255)));
      repeat (3 + $urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom));
      return;
    end
    units = $urandom_range(1, 4);
    for (u = 0; u < units; u++) begin
      len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'h00);
      pkt_bytes.push_back(8'(len));
      case ($urandom_range(0, 5))
        0:       ntype = NAL_SLICE;
        1, 4:    ntype = NAL_IDR;
        2:       ntype = NAL_SPS;
        3:       ntype = NAL_PPS;
        default: ntype = 5'($urandom);
      endcase
      for (j = 0; j < len; j++)
        pkt_bytes.push_back((j == 0) ? {3'($urandom), ntype} : 8'($urandom));
    end
    if (broken && pkt_bytes.size() > 1) begin
      cut = $urandom_range(1, pkt_bytes.size() - 1);
      while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fill every store slot; an index past the depth must be ignored
  task automatic load_param_store();
    int i;
    for (i = 0; i < PS_DEPTH; i++)
      send_request(CMD_STORE, 8'($urandom), 6'(i), 1'($urandom));
    send_request(CMD_STORE, 8'hff, 6'd63, 1'b1);
    send_request(CMD_STORE, 8'h00, 6'd0, 1'b0);
  endtask

  task automatic test_directed_cases();
    // PPS as a one-byte unit, no SPS before it: replay + long start code
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h68};
    send_packet();
    // zero-length unit, then IDR starting a new picture
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h02,
                  8'h65, 8'h80};
    send_packet();
    // length of 2^31: rest of packet dropped, error at end
    pkt_bytes = '{8'h80, 8'h00, 8'h00, 8'h00, 8'haa};
    send_packet();
    // packet ends inside the length prefix
    pkt_bytes = '{8'hff, 8'h05};
    send_packet();
    // plain slice, packet ends inside the unit
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h03, 8'h41, 8'h9a};
    send_packet();
  endtask

  task automatic test_random_packets(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      if ($urandom_range(0, 9) == 0)
        send_request(CMD_STORE, 8'($urandom), 6'($urandom_range(0, 63)), 1'($urandom));
      build_random_packet($urandom_range(0, 6) == 0);
      send_packet();
      sent += pkt_bytes.size();
    end
  endtask

  task automatic test_back_to_back(input int n_bytes);
    tx_gap_max = 0;
    rx_gap_max = 0;
    test_random_packets(n_bytes);
    tx_gap_max = TX_GAP_DEFAULT;
    rx_gap_max = RX_GAP_DEFAULT;
  endtask

  // Receiver stalls for a long stretch while input keeps coming, long replay first
  task automatic test_output_stall();
    tx_gap_max  = 0;
    rx_hold_req = 1'b1;
    pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h02, 8'h25, 8'h80};
    send_packet();
    build_random_packet(1'b0);
    send_packet();
    tx_gap_max = TX_GAP_DEFAULT;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready, with an occasional long hold
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int pause;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
      end
      pause = $urandom_range(0, rx_gap_max);
      if (pause > 0) begin
        out_tready <= 1'b0;
        repeat (pause) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    annexb_beat_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      if (expected_beats.size() == 0) begin
        $error("unexpected result: out_byte=%0h user=%b last=%b",
               out_tdata, out_tuser, out_tlast);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (out_tdata !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, out_tdata);
          mismatches++;
        end
        if (out_tuser[0] !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, out_tuser[0]);
          mismatches++;
        end
        if (out_tuser[1] !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, out_tuser[1]);
          mismatches++;
        end
        if (out_tlast !== want.packet_done) begin
          $error("packet_done: expected %0b, got %0b", want.packet_done, out_tlast);
          mismatches++;
        end
        if (out_tuser[2] !== want.format_error) begin
          $error("format_error: expected %0b, got %0b", want.format_error, out_tuser[2]);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run: too long with no handshake anywhere
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("h264_length_prefix_to_start_code: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    clear_packet();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    load_param_store();
    write_param_length(6'd8);
    test_directed_cases();
    write_param_length(6'd0);
    test_random_packets(6);
    write_param_length(6'd48);
    test_output_stall();
    write_param_length(6'd63);   // above depth: saturates
    test_random_packets(6);
    write_param_length(6'($urandom_range(1, 47)));
    test_back_to_back(6);
    write_param_length(6'd1);
    test_random_packets(4);

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0)
      $display("h264_length_prefix_to_start_code: match");
    else
      $display("h264_length_prefix_to_start_code: mismatch");
    $finish;
  end

endmodule

>>> files.f
sv/lp2sc_pkg.sv
sv/h264_length_prefix_to_start_code.sv
tb/sv/tb_top.sv
